// ----- hdl/dcd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcd_pkg
// types, codes and byte-class rules shared by the double-byte char decoder
// ----------------------------------------------------------------------------
package dcd_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CJK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LANG = 2'd1;

    localparam logic [3:0] LANG_NONE   = 4'd0;
    localparam logic [3:0] LANG_GB2312 = 4'd8;
    localparam logic [3:0] LANG_BIG5   = 4'd9;
    localparam logic [3:0] LANG_SJIS   = 4'd10;
    localparam logic [3:0] LANG_UHC    = 4'd11;

    localparam logic [7:0] CARET      = 8'h5E;
    localparam logic [7:0] LF         = 8'h0A;
    localparam logic [7:0] CR         = 8'h0D;
    localparam logic [7:0] COLOR_LO   = 8'h30;
    localparam logic [7:0] COLOR_HI   = 8'h40;

    localparam logic [1:0] KIND_PRINT   = 2'd0;
    localparam logic [1:0] KIND_NEWLINE = 2'd1;
    localparam logic [1:0] KIND_COLOR   = 2'd2;

    localparam logic [1:0] HELD_NONE  = 2'd0;
    localparam logic [1:0] HELD_LEAD  = 2'd1;
    localparam logic [1:0] HELD_CARET = 2'd2;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [15:0] char_code;
        logic [1:0]  byte_count;
        logic [1:0]  char_kind;
        logic [7:0]  color_byte;
        logic [15:0] printable_count;
        logic        run_end;
        logic        string_done;
    } t_result;

    function automatic logic lead_ok(input logic [3:0] mode, input logic [7:0] b);
        logic ok;
        case (mode)
            LANG_GB2312: ok = b inside {[8'hB0:8'hC8]};
            LANG_BIG5:   ok = b inside {[8'hA1:8'hC6], [8'hC9:8'hF9]};
            LANG_SJIS:   ok = b inside {[8'h81:8'h9F], [8'hE0:8'hEF]};
            LANG_UHC:    ok = b inside {[8'h81:8'hFE]};
            default:     ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic logic trail_ok(input logic [3:0] mode, input logic [7:0] b);
        logic ok;
        case (mode)
            LANG_GB2312: ok = b inside {[8'hA1:8'hFE]};
            LANG_BIG5:   ok = b inside {[8'h40:8'h7E], [8'hA1:8'hFE]};
            LANG_SJIS:   ok = b inside {[8'h40:8'h7E], [8'h80:8'hFC]};
            LANG_UHC:    ok = b inside {[8'h41:8'hFE]};
            default:     ok = 1'b0;
        endcase
        return ok;
    endfunction

    // saturating increment of the printable count
    function automatic logic [15:0] count_inc(input logic [15:0] c, input logic en);
        return (en && (c != COUNT_MAX)) ? c + 16'd1 : c;
    endfunction

endpackage

// ----- hdl/dcd_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcd channel interfaces
// valid/ready channels for input bytes, decoded characters and config writes
// ----------------------------------------------------------------------------
interface dcd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       string_end;

    modport source (output valid, output in_byte, output string_end, input ready);
    modport sink   (input valid, input in_byte, input string_end, output ready);
endinterface

interface dcd_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] char_code;
    logic [1:0]  byte_count;
    logic [1:0]  char_kind;
    logic [7:0]  color_byte;
    logic [15:0] printable_count;
    logic        run_end;
    logic        string_done;

    modport source (output valid, output char_code, output byte_count, output char_kind,
                    output color_byte, output printable_count, output run_end,
                    output string_done, input ready);
    modport sink   (input valid, input char_code, input byte_count, input char_kind,
                    input color_byte, input printable_count, input run_end,
                    input string_done, output ready);
endinterface

interface dcd_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [3:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/dbcs_char_decoder_with_length.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbcs_char_decoder_with_length
// double-byte aware text decoder with colour codes and printable length
// ----------------------------------------------------------------------------
// Takes one text byte per beat on i_in and sends decoded characters on o_out.
// With cjk_enabled set and language_code 8..11 a lead byte is held until the
// next byte, which either completes a 16-bit pair or causes the lead to be
// sent alone; a caret is held the same way to detect a colour code. So a
// byte yields zero, one or two characters. The block accepts one byte per
// cycle while o_out is ready: a byte is held in the input register, is
// decoded in one pass into the result register (both characters at once),
// and the result register drains one character per beat. A byte that
// yields two characters holds the input side until its second character
// has been taken. An input beat passes the input register and then the
// result register before it reaches o_out. Config writes are always
// accepted and take effect on the next decoded byte; they should be done
// with the block idle.
// ----------------------------------------------------------------------------
module dbcs_char_decoder_with_length
    import dcd_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    dcd_cfg_if.sink       i_cfg,
    dcd_in_if.sink        i_in,
    dcd_out_if.source     o_out
);

    // config registers
    logic       r_cjk;
    logic [3:0] r_lang;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_end;

    // decoder state
    logic [1:0]  r_held_kind, n_held_kind;
    logic [7:0]  r_held_byte, n_held_byte;
    logic [15:0] r_len, n_len;

    // result register: up to two characters of one byte
    logic    r_res_valid;
    logic    r_two;
    logic    r_sel;
    t_result r_slot0, r_slot1;
    t_result n_slot0, n_slot1;
    logic    n_two, n_any;

    logic       adv, pop, last, res_free;
    logic [3:0] mode;
    logic       pair, color, combined, has_a, has_b, f_lead, f_caret;
    t_result    res_a, res_b, cur;
    logic [15:0] cnt_a, cnt_b;

    // ------------------------------------------------------------------
    // config port: never stalls, indexes beyond the list are dropped
    // ------------------------------------------------------------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cjk  <= 1'b0;
            r_lang <= LANG_NONE;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_IDX_CJK:  r_cjk  <= i_cfg.data[0];
                CFG_IDX_LANG: r_lang <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // handshake control
    // ------------------------------------------------------------------
    assign pop      = r_res_valid && o_out.ready;
    assign last     = r_sel || !r_two;
    assign res_free = !r_res_valid || (pop && last);
    assign adv      = r_in_valid && res_free;

    assign i_in.ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    // input payload needs no reset
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.in_byte;
            r_in_end  <= i_in.string_end;
        end
    end

    // ------------------------------------------------------------------
    // decode of the byte in the input register
    // ------------------------------------------------------------------
    always_comb begin
        // double-byte rules only for the four known languages
        mode = (r_cjk && (r_lang inside {[LANG_GB2312:LANG_UHC]})) ? r_lang : LANG_NONE;

        pair     = (r_held_kind == HELD_LEAD) && lead_ok(mode, r_held_byte)
                   && trail_ok(mode, r_in_byte);
        color    = (r_held_kind == HELD_CARET) && (r_in_byte inside {[COLOR_LO:COLOR_HI]});
        combined = pair || color;
        has_a    = (r_held_kind == HELD_LEAD) || (r_held_kind == HELD_CARET);

        // fresh handling of the new byte when it was not absorbed by the held one
        f_lead  = !r_in_end && lead_ok(mode, r_in_byte);
        f_caret = !r_in_end && !f_lead && (r_in_byte == CARET);
        has_b   = !combined && !f_lead && !f_caret;

        // first character: from the held byte
        res_a = '0;
        if (pair) begin
            res_a.char_code  = {r_held_byte, r_in_byte};
            res_a.byte_count = 2'd2;
            res_a.char_kind  = KIND_PRINT;
        end else if (color) begin
            res_a.char_code  = {8'h00, CARET};
            res_a.byte_count = 2'd1;
            res_a.char_kind  = KIND_COLOR;
            res_a.color_byte = r_in_byte;
        end else begin
            // failed pair or lone caret goes out as a plain byte
            res_a.char_code  = {8'h00, r_held_byte};
            res_a.byte_count = 2'd1;
            res_a.char_kind  = ((r_held_byte == LF) || (r_held_byte == CR))
                               ? KIND_NEWLINE : KIND_PRINT;
        end
        cnt_a = count_inc(r_len, has_a && (res_a.char_kind == KIND_PRINT));
        res_a.printable_count = cnt_a;
        res_a.run_end         = !has_b;
        res_a.string_done     = !has_b && r_in_end;

        // second character: the new byte on its own
        res_b = '0;
        res_b.char_code  = {8'h00, r_in_byte};
        res_b.byte_count = 2'd1;
        res_b.char_kind  = ((r_in_byte == LF) || (r_in_byte == CR))
                           ? KIND_NEWLINE : KIND_PRINT;
        cnt_b = count_inc(cnt_a, has_b && (res_b.char_kind == KIND_PRINT));
        res_b.printable_count = cnt_b;
        res_b.run_end         = 1'b1;
        res_b.string_done     = r_in_end;

        // pack the characters to the front of the result register
        n_slot0 = has_a ? res_a : res_b;
        n_slot1 = res_b;
        n_two   = has_a && has_b;
        n_any   = has_a || has_b;

        // next held state and count
        if (r_in_end) begin
            n_held_kind = HELD_NONE;
            n_held_byte = 8'h00;
            n_len       = 16'd0;
        end else begin
            if (combined) begin
                n_held_kind = HELD_NONE;
            end else if (f_lead) begin
                n_held_kind = HELD_LEAD;
            end else if (f_caret) begin
                n_held_kind = HELD_CARET;
            end else begin
                n_held_kind = HELD_NONE;
            end
            n_held_byte = (n_held_kind == HELD_NONE) ? 8'h00 : r_in_byte;
            n_len       = cnt_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_kind <= HELD_NONE;
            r_held_byte <= 8'h00;
            r_len       <= 16'd0;
        end else if (adv) begin
            r_held_kind <= n_held_kind;
            r_held_byte <= n_held_byte;
            r_len       <= n_len;
        end
    end

    // ------------------------------------------------------------------
    // result register, drained one character per beat
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
            r_two       <= 1'b0;
            r_sel       <= 1'b0;
        end else if (adv) begin
            r_res_valid <= n_any;
            r_two       <= n_two;
            r_sel       <= 1'b0;
        end else if (pop && !last) begin
            // first of two sent, show the second
            r_sel <= 1'b1;
        end else if (pop) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_slot0 <= n_slot0;
            r_slot1 <= n_slot1;
        end
    end

    assign cur = r_sel ? r_slot1 : r_slot0;

    assign o_out.valid           = r_res_valid;
    assign o_out.char_code       = cur.char_code;
    assign o_out.byte_count      = cur.byte_count;
    assign o_out.char_kind       = cur.char_kind;
    assign o_out.color_byte      = cur.color_byte;
    assign o_out.printable_count = cur.printable_count;
    assign o_out.run_end         = cur.run_end;
    assign o_out.string_done     = cur.string_done;

endmodule

// ----- hdl/dcd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcd_checker
// port-level checks on the decoder output channel
// ----------------------------------------------------------------------------
module dcd_checker
    import dcd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_char_code,
    input logic [1:0]  i_byte_count,
    input logic [1:0]  i_char_kind,
    input logic [7:0]  i_color_byte,
    input logic [15:0] i_printable_count,
    input logic        i_run_end,
    input logic        i_string_done
);

    // stalled beat keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_char_code)
            && $stable(i_printable_count) && $stable(i_run_end))
        else $error("output beat changed while stalled");

    // a counted character always leaves a nonzero count
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_char_kind == KIND_PRINT) |-> (i_printable_count != 16'd0))
        else $error("printable character with zero count");

    // colour beat: caret, one byte, code byte in range
    a_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_char_kind == KIND_COLOR) |-> (i_char_code == {8'h00, CARET})
            && (i_byte_count == 2'd1) && (i_color_byte >= COLOR_LO)
            && (i_color_byte <= COLOR_HI))
        else $error("malformed colour code beat");

    // pairs are printable and carry a lead byte
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_byte_count == 2'd2) |-> (i_char_kind == KIND_PRINT)
            && (i_char_code[15:8] != 8'h00) && (i_color_byte == 8'h00))
        else $error("malformed double-byte beat");

    // end of string is always the last character of its byte
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_string_done |-> i_run_end)
        else $error("string end without run end");

endmodule

bind dbcs_char_decoder_with_length dcd_checker u_dcd_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_char_code       (o_out.char_code),
    .i_byte_count      (o_out.byte_count),
    .i_char_kind       (o_out.char_kind),
    .i_color_byte      (o_out.color_byte),
    .i_printable_count (o_out.printable_count),
    .i_run_end         (o_out.run_end),
    .i_string_done     (o_out.string_done)
);

// ----- bench/tb_dbcs_char_decoder_with_length.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dbcs_char_decoder_with_length
// self-checking bench for the double-byte text decoder with printable count
// ----------------------------------------------------------------------------
// Text bytes are pushed into the decoder one beat at a time. Each accepted
// beat runs through a behavioral decoder kept in this bench, which queues the
// characters the block should send. A monitor compares every output beat with
// the oldest queued character, field by field. The run covers directed
// strings, a hold-off on the output that fills the block, and random strings
// under every double-byte language and several single-byte settings. Idle
// gaps and output stalls come in short random bursts.
// ----------------------------------------------------------------------------
module tb_dbcs_char_decoder_with_length;
    import dcd_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_PAD    = 8;      // margin after the queue drains, padded generously
    localparam int HOLD_CYCLES  = 80;     // long output hold-off
    localparam int RAND_ITEMS   = 1250;
    localparam int NUM_PHASES   = 8;

    // language codes outside the double-byte set
    localparam logic [3:0] LANG_RSVD = 4'd12;
    localparam logic [3:0] LANG_TOP  = 4'd15;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    dcd_cfg_if cfg_if ();
    dcd_in_if  in_if  ();
    dcd_out_if out_if ();

    dbcs_char_decoder_with_length dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // behavioral decoder state, mirrors the block after reset
    // ------------------------------------------------------------------------
    logic        cfg_cjk   = 1'b0;
    logic [3:0]  cfg_lang  = LANG_NONE;
    logic [7:0]  held_byte = 8'h00;
    logic [1:0]  held_kind = HELD_NONE;
    logic [15:0] len_cnt   = 16'h0000;

    t_result     char_q[$];      // characters still owed by the block
    t_result     step_res[2];    // characters caused by the current byte
    int          step_n;

    logic [7:0]  str_q[$];       // text of the string being built
    int          err_cnt    = 0;
    int          cyc_cnt    = 0;
    bit          idle_on    = 1'b0;
    bit          hold_req   = 1'b0;
    int          stall_left = 0;

    // language in force for pair decoding, none unless enabled and 8..11
    function automatic logic [3:0] pair_lang();
        if (!cfg_cjk)
            return LANG_NONE;
        if (cfg_lang >= LANG_GB2312 && cfg_lang <= LANG_UHC)
            return cfg_lang;
        return LANG_NONE;
    endfunction

    function automatic bit is_lead(input logic [7:0] b);
        case (pair_lang())
            LANG_GB2312: return b >= 8'hB0 && b <= 8'hC8;
            LANG_BIG5:   return (b >= 8'hA1 && b <= 8'hC6) || (b >= 8'hC9 && b <= 8'hF9);
            LANG_SJIS:   return (b >= 8'h81 && b <= 8'h9F) || (b >= 8'hE0 && b <= 8'hEF);
            LANG_UHC:    return b >= 8'h81 && b <= 8'hFE;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit is_trail(input logic [7:0] b);
        case (pair_lang())
            LANG_GB2312: return b >= 8'hA1 && b <= 8'hFE;
            LANG_BIG5:   return (b >= 8'h40 && b <= 8'h7E) || (b >= 8'hA1 && b <= 8'hFE);
            LANG_SJIS:   return (b >= 8'h40 && b <= 8'h7E) || (b >= 8'h80 && b <= 8'hFC);
            LANG_UHC:    return b >= 8'h41 && b <= 8'hFE;
            default:     return 1'b0;
        endcase
    endfunction

    // one decoded character, printable ones bump the saturating count
    function automatic void add_char(input logic [15:0] code, input logic [1:0] nbytes,
                                     input logic [1:0] kind, input logic [7:0] color);
        t_result r;
        if (kind == KIND_PRINT && len_cnt != COUNT_MAX)
            len_cnt = len_cnt + 16'd1;
        r.char_code       = code;
        r.byte_count      = nbytes;
        r.char_kind       = kind;
        r.color_byte      = color;
        r.printable_count = len_cnt;
        r.run_end         = 1'b0;
        r.string_done     = 1'b0;
        step_res[step_n]  = r;
        step_n++;
    endfunction

    function automatic void add_single(input logic [7:0] b);
        add_char({8'h00, b}, 2'd1, (b == LF || b == CR) ? KIND_NEWLINE : KIND_PRINT, 8'h00);
    endfunction

    // byte with nothing held: hold a lead or caret unless the string ends
    function automatic void take_fresh(input logic [7:0] b, input logic last);
        held_kind = HELD_NONE;
        held_byte = 8'h00;
        if (!last && is_lead(b)) begin
            held_kind = HELD_LEAD;
            held_byte = b;
        end else if (!last && b == CARET) begin
            held_kind = HELD_CARET;
            held_byte = b;
        end else begin
            add_single(b);
        end
    endfunction

    // advance the decoder by one accepted byte and queue what it yields
    function automatic void decode_byte(input logic [7:0] b, input logic last);
        logic [7:0] h;
        h      = held_byte;
        step_n = 0;
        if (held_kind == HELD_LEAD) begin
            // pair judged against the mode in force now
            if (is_lead(h) && is_trail(b)) begin
                held_kind = HELD_NONE;
                held_byte = 8'h00;
                add_char({h, b}, 2'd2, KIND_PRINT, 8'h00);
            end else begin
                add_single(h);
                take_fresh(b, last);
            end
        end else if (held_kind == HELD_CARET) begin
            if (b >= COLOR_LO && b <= COLOR_HI) begin
                held_kind = HELD_NONE;
                held_byte = 8'h00;
                add_char({8'h00, CARET}, 2'd1, KIND_COLOR, b);
            end else begin
                // lone caret is an ordinary printable
                add_single(CARET);
                take_fresh(b, last);
            end
        end else begin
            take_fresh(b, last);
        end
        if (step_n > 0) begin
            step_res[step_n-1].run_end     = 1'b1;
            step_res[step_n-1].string_done = last;
        end
        for (int i = 0; i < step_n; i++)
            char_q.push_back(step_res[i]);
        if (last) begin
            held_kind = HELD_NONE;
            held_byte = 8'h00;
            len_cnt   = 16'h0000;
        end
    endfunction

    // ------------------------------------------------------------------------
    // output side: ready with random stalls and an on-demand long hold
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready = 1'b0;
        end else if (hold_req) begin
            hold_req     = 1'b0;
            stall_left   = HOLD_CYCLES - 1;
            out_if.ready = 1'b0;
        end else if (stall_left > 0) begin
            stall_left   = stall_left - 1;
            out_if.ready = 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left   = $urandom_range(0, 2);
            out_if.ready = 1'b0;
        end else begin
            out_if.ready = 1'b1;
        end
    end

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            err_cnt++;
            $error("%s: expected %0h, actual %0h", name, want, got);
        end
    endfunction

    // every output beat is matched against the oldest owed character
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (char_q.size() == 0) begin
                err_cnt++;
                $error("char_code: expected none, actual %0h", out_if.char_code);
            end else begin
                want = char_q.pop_front();
                check_field("char_code",       want.char_code,       out_if.char_code);
                check_field("byte_count",      16'(want.byte_count),
                            16'(out_if.byte_count));
                check_field("char_kind",       16'(want.char_kind),
                            16'(out_if.char_kind));
                check_field("color_byte",      16'(want.color_byte),
                            16'(out_if.color_byte));
                check_field("printable_count", want.printable_count, out_if.printable_count);
                check_field("run_end",         16'(want.run_end),
                            16'(out_if.run_end));
                check_field("string_done",     16'(want.string_done),
                            16'(out_if.string_done));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cyc_cnt++;
        if (cyc_cnt > LIMIT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // called at a falling edge, returns at a falling edge with valid left high
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            in_if.valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        in_if.valid      = 1'b1;
        in_if.in_byte    = b;
        in_if.string_end = last;
        do @(posedge i_clk); while (!in_if.ready);
        decode_byte(b, last);
        @(negedge i_clk);
    endtask

    // sends the built string, end flag on its last byte
    task automatic send_text(output int sent);
        sent = str_q.size();
        for (int i = 0; i < str_q.size(); i++)
            send_byte(str_q[i], i == str_q.size() - 1);
        str_q.delete();
    endtask

    // drop valid, let every owed character drain, then allow for latency
    task automatic wait_idle();
        in_if.valid = 1'b0;
        while (char_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_PAD) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = val;
        do @(posedge i_clk); while (!cfg_if.ready);
        if (idx == CFG_IDX_CJK)
            cfg_cjk = val[0];
        else if (idx == CFG_IDX_LANG)
            cfg_lang = val;
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    function automatic logic [7:0] pick_lead();
        logic [7:0] b;
        case (pair_lang())
            LANG_GB2312: b = 8'($urandom_range(8'hB0, 8'hC8));
            LANG_BIG5:   b = 8'($urandom_range(0, 1) ? $urandom_range(8'hA1, 8'hC6)
                                                     : $urandom_range(8'hC9, 8'hF9));
            LANG_SJIS:   b = 8'($urandom_range(0, 1) ? $urandom_range(8'h81, 8'h9F)
                                                     : $urandom_range(8'hE0, 8'hEF));
            LANG_UHC:    b = 8'($urandom_range(8'h81, 8'hFE));
            default:     b = 8'($urandom_range(1, 255));
        endcase
        return b;
    endfunction

    function automatic logic [7:0] pick_trail();
        logic [7:0] b;
        case (pair_lang())
            LANG_GB2312: b = 8'($urandom_range(8'hA1, 8'hFE));
            LANG_BIG5:   b = 8'($urandom_range(0, 1) ? $urandom_range(8'h40, 8'h7E)
                                                     : $urandom_range(8'hA1, 8'hFE));
            LANG_SJIS:   b = 8'($urandom_range(0, 1) ? $urandom_range(8'h40, 8'h7E)
                                                     : $urandom_range(8'h80, 8'hFC));
            LANG_UHC:    b = 8'($urandom_range(8'h41, 8'hFE));
            default:     b = 8'($urandom_range(1, 255));
        endcase
        return b;
    endfunction

    // appends one random piece of text: mostly well-formed, some broken
    function automatic void add_token();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            str_q.push_back(pick_lead());
            str_q.push_back(pick_trail());
        end else if (r < 50) begin
            str_q.push_back(CARET);
            str_q.push_back(8'($urandom_range(COLOR_LO, COLOR_HI)));
        end else if (r < 58) begin
            str_q.push_back($urandom_range(0, 1) ? LF : CR);
        end else if (r < 78) begin
            str_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
        end else if (r < 88) begin
            str_q.push_back(8'($urandom_range(1, 255)));
        end else if (r < 94) begin
            // caret with a random follower, usually not a colour
            str_q.push_back(CARET);
            str_q.push_back(8'($urandom_range(1, 255)));
        end else begin
            // lead on its own, its follower is whatever comes next
            str_q.push_back(pick_lead());
        end
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // single-byte mode: extremes, newline kinds, colour bounds, lone carets
    task automatic test_single_bytes();
        int n;
        str_q = '{8'h01, 8'hFF, LF, CR, CARET, COLOR_LO, CARET, COLOR_HI,
                  CARET, 8'h41, 8'h00, 8'hB0, CARET};
        send_text(n);
        wait_idle();
    endtask

    // GB2312 pairs, failed pairs, lead at end, lead held over a mode change
    task automatic test_gb_pairs();
        int n;
        cfg_write(CFG_IDX_CJK, 4'd1);
        cfg_write(CFG_IDX_LANG, LANG_GB2312);
        // lowest and highest pair, bad trail, lead that falls onto a colour code
        str_q = '{8'hB0, 8'hA1, 8'hC8, 8'hFE, 8'hB0, 8'hA0, 8'hB0, CARET, 8'h31, 8'hC8};
        send_text(n);
        wait_idle();
        // lead stays held while pairing is switched off, then fails
        send_byte(8'hB0, 1'b0);
        wait_idle();
        cfg_write(CFG_IDX_CJK, 4'd0);
        send_byte(8'hA1, 1'b1);
        wait_idle();
    endtask

    // output held off while input keeps coming, then a full drain
    task automatic test_output_hold();
        int n;
        idle_on  = 1'b0;
        hold_req = 1'b1;
        for (int i = 0; i < 6; i++)
            add_token();
        for (int i = 0; i < 30; i++)
            str_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
        send_text(n);
        wait_idle();
    endtask

    // random strings under each language setting, last phase without gaps
    task automatic test_random_text();
        logic       cjk_list  [NUM_PHASES];
        logic [3:0] lang_list [NUM_PHASES];
        int         sent;
        int         n;
        cjk_list  = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};
        lang_list = '{LANG_GB2312, LANG_BIG5, LANG_SJIS, LANG_UHC,
                      LANG_NONE, LANG_TOP, LANG_RSVD, LANG_UHC};
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            cfg_write(CFG_IDX_CJK, {3'b000, cjk_list[p]});
            cfg_write(CFG_IDX_LANG, lang_list[p]);
            idle_on = (p != NUM_PHASES - 1);
            sent    = 0;
            while (sent < RAND_ITEMS / NUM_PHASES) begin
                repeat ($urandom_range(1, 8)) add_token();
                send_text(n);
                sent += n;
            end
        end
        wait_idle();
    endtask

    initial begin
        cfg_if.valid     = 1'b0;
        cfg_if.index     = CFG_IDX_CJK;
        cfg_if.data      = 4'd0;
        in_if.valid      = 1'b0;
        in_if.in_byte    = 8'h00;
        in_if.string_end = 1'b0;
        out_if.ready     = 1'b0;

        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        idle_on = 1'b1;
        test_single_bytes();
        test_gb_pairs();
        idle_on = 1'b1;
        test_output_hold();
        test_random_text();

        if (err_cnt == 0 && char_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/dcd_pkg.sv
hdl/dcd_ifs.sv
hdl/dbcs_char_decoder_with_length.sv
hdl/dcd_checker.sv
bench/tb_dbcs_char_decoder_with_length.sv
